>>> src/lcs_length_dp_defines.svh
// Assertion macros for the LCS length block. Each expects clk and arst_n in scope.
`ifndef LCS_LENGTH_DP_DEFINES_SVH
`define LCS_LENGTH_DP_DEFINES_SVH
`ifndef SYNTHESIS
`define LCS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define LCS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LCS_ASSERT_ALWAYS(lbl, expr, msg)
`define LCS_ASSERT_IMPL(lbl, ante, cons, msg)
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/lcs_pkg.sv
`default_nettype none
package lcs_pkg;

	localparam int unsigned SYM_W = 8;
	localparam int unsigned OUT_W = 7;

	localparam logic WS_X = 1'b0;
	localparam logic WS_Y = 1'b1;

	// Control bits of one y token moving down the cell row
	typedef struct packed {
		logic valid;
		logic last;
		logic upd;
	} tok_ctl_t;

endpackage
`default_nettype wire

>>> src/lcs_ifs.sv
`default_nettype none
interface lcs_sym_if import lcs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             which_string;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source(output valid, which_string, symbol, last, input ready);
	modport sink(input valid, which_string, symbol, last, output ready);
endinterface

interface lcs_res_if import lcs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] lcs_length;
	logic [OUT_W-1:0] x_length;
	logic [OUT_W-1:0] y_length;
	logic             error;

	modport source(output valid, lcs_length, x_length, y_length, error, input ready);
	modport sink(input valid, lcs_length, x_length, y_length, error, output ready);
endinterface
`default_nettype wire

>>> src/lcs_cell.sv
`default_nettype none
module lcs_cell import lcs_pkg::*; #(
	parameter int unsigned MAX_LEN = 64,
	localparam int unsigned CW = $clog2(MAX_LEN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             x_we,
	input  logic [SYM_W-1:0] x_sym,
	input  tok_ctl_t         in_ctl,
	input  logic [SYM_W-1:0] in_sym,
	input  logic [CW-1:0]    in_cnt,
	input  logic [CW-1:0]    in_left,
	input  logic [CW-1:0]    in_diag,
	output tok_ctl_t         out_ctl,
	output logic [SYM_W-1:0] out_sym,
	output logic [CW-1:0]    out_cnt,
	output logic [CW-1:0]    out_left,
	output logic [CW-1:0]    out_diag
);

	logic [SYM_W-1:0] x_q;
	logic [CW-1:0]    d_q;
	tok_ctl_t         ctl_q;
	logic [SYM_W-1:0] sym_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    left_q;
	logic [CW-1:0]    diag_q;

	logic          act;
	logic [CW-1:0] vmax;
	logic [CW-1:0] vcalc;
	logic [CW-1:0] v;

	// Cell is part of the x string while the token still has cells to cover
	assign act   = (in_cnt != '0);
	assign vmax  = (in_left >= d_q) ? in_left : d_q;
	assign vcalc = !in_ctl.upd ? d_q :
		(x_q == in_sym) ? (in_diag + CW'(1)) : vmax;
	assign v     = act ? vcalc : in_left;

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_q <= x_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q   <= '0;
			ctl_q <= '0;
		end else begin
			ctl_q <= in_ctl;
			if (in_ctl.valid) begin
				// last token leaves the row cleared behind it
				if (in_ctl.last) begin
					d_q <= '0;
				end else if (act && in_ctl.upd) begin
					d_q <= vcalc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sym_q  <= in_sym;
		cnt_q  <= act ? (in_cnt - CW'(1)) : '0;
		left_q <= v;
		diag_q <= d_q;
	end

	assign out_ctl  = ctl_q;
	assign out_sym  = sym_q;
	assign out_cnt  = cnt_q;
	assign out_left = left_q;
	assign out_diag = diag_q;

endmodule
`default_nettype wire

>>> src/lcs_ctrl.sv
`default_nettype none
`include "lcs_length_dp_defines.svh"
module lcs_ctrl import lcs_pkg::*; #(
	parameter int unsigned MAX_LEN = 64,
	localparam int unsigned CW = $clog2(MAX_LEN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	lcs_sym_if.sink          symbols,
	lcs_res_if.source        results,
	output logic             x_we,
	output logic [CW-1:0]    x_idx,
	output logic [SYM_W-1:0] x_sym,
	output tok_ctl_t         ent_ctl,
	output logic [SYM_W-1:0] ent_sym,
	output logic [CW-1:0]    ent_cnt,
	input  tok_ctl_t         ext_ctl,
	input  logic [CW-1:0]    ext_len
);

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_DRAIN = 3'b010,
		ST_HOLD  = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] x_count_q;
	logic [CW-1:0] y_count_q;
	logic          err_q;

	logic [OUT_W-1:0] pend_lcs_q;
	logic [OUT_W-1:0] pend_xlen_q;
	logic [OUT_W-1:0] pend_ylen_q;
	logic             pend_err_q;

	logic             res_valid_q;
	logic [OUT_W-1:0] res_lcs_q;
	logic [OUT_W-1:0] res_xlen_q;
	logic [OUT_W-1:0] res_ylen_q;
	logic             res_err_q;

	logic          accept;
	logic          is_y;
	logic          x_ok;
	logic          y_ok;
	logic [CW-1:0] y_count_nx;
	logic          err_nx;
	logic          end_pair;
	logic          exit_last;
	logic          out_free;
	logic          out_load;

	assign symbols.ready = (state_q == ST_RUN);
	assign accept        = symbols.valid && symbols.ready;
	assign is_y          = (symbols.which_string == WS_Y);

	// x is refused once y has started or the row is full
	assign x_ok       = (y_count_q == '0) && (x_count_q != CW'(MAX_LEN));
	assign y_ok       = (y_count_q != CW'(MAX_LEN));
	assign y_count_nx = y_ok ? (y_count_q + CW'(1)) : y_count_q;
	assign err_nx     = err_q | (is_y ? !y_ok : !x_ok);
	assign end_pair   = accept && is_y && symbols.last;

	assign x_we  = accept && !is_y && x_ok;
	assign x_idx = x_count_q;
	assign x_sym = symbols.symbol;

	// an overflowed y still runs down the row, without update, to read the result
	assign ent_ctl.valid = accept && is_y;
	assign ent_ctl.last  = symbols.last;
	assign ent_ctl.upd   = y_ok;
	assign ent_sym       = symbols.symbol;
	assign ent_cnt       = x_count_q;

	assign exit_last = ext_ctl.valid && ext_ctl.last;
	assign out_free  = !res_valid_q || results.ready;
	assign out_load  = (state_q == ST_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			x_count_q <= '0;
			y_count_q <= '0;
			err_q     <= 1'b0;
		end else begin
			if (accept) begin
				if (end_pair) begin
					x_count_q <= '0;
					y_count_q <= '0;
					err_q     <= 1'b0;
				end else begin
					if (x_we) begin
						x_count_q <= x_count_q + CW'(1);
					end
					if (is_y) begin
						y_count_q <= y_count_nx;
					end
					err_q <= err_nx;
				end
			end
			case (state_q)
				ST_RUN: begin
					if (end_pair) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (exit_last) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (end_pair) begin
			pend_xlen_q <= OUT_W'(x_count_q);
			pend_ylen_q <= OUT_W'(y_count_nx);
			pend_err_q  <= err_nx;
		end
		if (exit_last) begin
			pend_lcs_q <= OUT_W'(ext_len);
		end
		if (out_load) begin
			res_lcs_q  <= pend_lcs_q;
			res_xlen_q <= pend_xlen_q;
			res_ylen_q <= pend_ylen_q;
			res_err_q  <= pend_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.lcs_length = res_lcs_q;
	assign results.x_length   = res_xlen_q;
	assign results.y_length   = res_ylen_q;
	assign results.error      = res_err_q;

	`LCS_ASSERT_NEXT(a_end_clears, end_pair, state_q == ST_DRAIN && x_count_q == '0 && y_count_q == '0 && !err_q, "pair end did not clear counters")
	`LCS_ASSERT_IMPL(a_exit_in_drain, exit_last, state_q == ST_DRAIN, "last token left the row outside drain")
	`LCS_ASSERT_ALWAYS(a_count_range, x_count_q <= CW'(MAX_LEN) && y_count_q <= CW'(MAX_LEN), "symbol count beyond row length")
	`LCS_ASSERT_NEXT(a_hold_loads, out_load, results.valid && state_q == ST_RUN, "held result not presented")

endmodule
`default_nettype wire

>>> src/lcs_length_dp.sv
`default_nettype none
// LCS length engine. Load x one byte per cycle (which_string = 0), then stream y one byte
// per cycle (which_string = 1); each x byte sits in its own cell of a MAX_LEN-cell row and
// each y byte travels down that row one cell per clock, so x and y requests are taken every
// cycle. On the y request marked last, input ready drops while that final token crosses the
// row and its result moves into the output register, after which the next pair may start;
// result-side stalls hold it off longer. The row clears itself behind the final token.
// Dropped symbols (x past MAX_LEN, y past MAX_LEN, x after y) set error in the result.
module lcs_length_dp import lcs_pkg::*; #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	lcs_sym_if.sink   symbols,
	lcs_res_if.source results
);

	localparam int unsigned CW = $clog2(MAX_LEN + 1);

	logic             x_we;
	logic [CW-1:0]    x_idx;
	logic [SYM_W-1:0] x_sym;

	// index 0 is the row entry, index i+1 the output of cell i
	tok_ctl_t         ctl_c  [MAX_LEN+1];
	logic [SYM_W-1:0] sym_c  [MAX_LEN+1];
	logic [CW-1:0]    cnt_c  [MAX_LEN+1];
	logic [CW-1:0]    left_c [MAX_LEN+1];
	logic [CW-1:0]    diag_c [MAX_LEN+1];

	assign left_c[0] = '0;
	assign diag_c[0] = '0;

	lcs_ctrl #(
		.MAX_LEN(MAX_LEN)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.symbols (symbols),
		.results (results),
		.x_we    (x_we),
		.x_idx   (x_idx),
		.x_sym   (x_sym),
		.ent_ctl (ctl_c[0]),
		.ent_sym (sym_c[0]),
		.ent_cnt (cnt_c[0]),
		.ext_ctl (ctl_c[MAX_LEN]),
		.ext_len (left_c[MAX_LEN])
	);

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		lcs_cell #(
			.MAX_LEN(MAX_LEN)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.x_we     (x_we && (x_idx == CW'(i))),
			.x_sym    (x_sym),
			.in_ctl   (ctl_c[i]),
			.in_sym   (sym_c[i]),
			.in_cnt   (cnt_c[i]),
			.in_left  (left_c[i]),
			.in_diag  (diag_c[i]),
			.out_ctl  (ctl_c[i+1]),
			.out_sym  (sym_c[i+1]),
			.out_cnt  (cnt_c[i+1]),
			.out_left (left_c[i+1]),
			.out_diag (diag_c[i+1])
		);
	end

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import lcs_pkg::*;

	localparam int LEN_MAX      = 64;
	localparam int LIMIT_CYCLES = 300000;
	localparam int RANDOM_ITEMS = 600;
	localparam int CALM_AFTER   = 510;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * LEN_MAX + 20;

	typedef struct packed {
		logic [OUT_W-1:0] lcs;
		logic [OUT_W-1:0] xl;
		logic [OUT_W-1:0] yl;
		logic             err;
	} pair_result_t;

	typedef struct packed {
		logic             ws;
		logic [SYM_W-1:0] sym;
		logic             lst;
		logic [6:0]       reps;
		logic             typed;
		pair_result_t     want;
	} stim_row_t;

	localparam pair_result_t NO_RES = '0;
	localparam int DIR_ROWS = 22;

	logic clk;
	logic arst_n;

	lcs_sym_if sym_ch();
	lcs_res_if res_ch();

	lcs_length_dp #(.MAX_LEN(LEN_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.symbols(sym_ch.sink),
		.results(res_ch.source)
	);

	// Shadow copy of the DP engine
	logic [SYM_W-1:0] x_syms [LEN_MAX];
	logic [OUT_W-1:0] row_len [LEN_MAX+1];
	logic [OUT_W-1:0] x_cnt;
	logic [OUT_W-1:0] y_cnt;
	logic             drop_seen;

	pair_result_t pending_lengths [$];
	stim_row_t    dir_rows [DIR_ROWS];

	int  fails;
	int  results_seen;
	int  items_sent;
	int  drops;
	int  cycles;
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_pair();
		int i;
		for (i = 0; i <= LEN_MAX; i++)
			row_len[i] = '0;
		x_cnt = '0;
		y_cnt = '0;
		drop_seen = 1'b0;
	endfunction

	function automatic bit lcs_advance(input logic ws, input logic [SYM_W-1:0] s,
			input logic lst, output pair_result_t r);
		logic [OUT_W-1:0] diag, above, left;
		int i;
		r = '0;
		if (ws == WS_X) begin
			if (y_cnt != 0 || x_cnt >= LEN_MAX) begin
				drop_seen = 1'b1;
				drops++;
			end else begin
				x_syms[x_cnt] = s;
				x_cnt++;
			end
			return 1'b0;
		end
		if (y_cnt >= LEN_MAX) begin
			drop_seen = 1'b1;
			drops++;
		end else begin
			diag = row_len[0];
			for (i = 1; i <= x_cnt; i++) begin
				above = row_len[i];
				left = row_len[i-1];
				if (x_syms[i-1] == s)
					row_len[i] = diag + 1'b1;
				else
					row_len[i] = (left >= above) ? left : above;
				diag = above;
			end
			y_cnt++;
		end
		if (!lst)
			return 1'b0;
		r.lcs = row_len[x_cnt];
		r.xl = x_cnt;
		r.yl = y_cnt;
		r.err = drop_seen;
		clear_pair();
		return 1'b1;
	endfunction

	// Offer one request, optionally after a random gap, and predict on acceptance
	task automatic send_sym(input logic ws, input logic [SYM_W-1:0] s, input logic lst,
			input logic typed, input pair_result_t want);
		pair_result_t r;
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			sym_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_ch.valid <= 1'b1;
		sym_ch.which_string <= ws;
		sym_ch.symbol <= s;
		sym_ch.last <= lst;
		do @(posedge clk); while (!sym_ch.ready);
		items_sent++;
		if (lcs_advance(ws, s, lst, r))
			pending_lengths.push_back(typed ? want : r);
	endtask

	function automatic logic [SYM_W-1:0] pick_sym(input logic [SYM_W-1:0] base, input bit narrow);
		if (narrow)
			return base ^ SYM_W'($urandom_range(0, 3));
		return SYM_W'($urandom_range(0, 255));
	endfunction

	task automatic random_pair();
		int nx, ny, shape, i, stray_at;
		logic [SYM_W-1:0] base;
		bit narrow;
		shape = $urandom_range(0, 19);
		narrow = $urandom_range(0, 2) != 0;
		base = SYM_W'($urandom_range(0, 255));
		case (shape)
			0: begin
				nx = LEN_MAX + $urandom_range(0, 2);
				ny = $urandom_range(1, 8);
			end
			1: begin
				nx = $urandom_range(1, 8);
				ny = LEN_MAX + $urandom_range(0, 2);
			end
			2: begin
				nx = LEN_MAX;
				ny = LEN_MAX;
			end
			3: begin
				nx = 0;
				ny = $urandom_range(1, 6);
			end
			default: begin
				nx = $urandom_range(1, 12);
				ny = $urandom_range(1, 12);
			end
		endcase
		// slip a stray x in between y requests now and then
		stray_at = (shape == 4 && ny > 1) ? $urandom_range(1, ny - 1) : -1;
		for (i = 0; i < nx; i++)
			send_sym(WS_X, pick_sym(base, narrow), $urandom_range(0, 7) == 0, 1'b0, NO_RES);
		for (i = 0; i < ny; i++) begin
			if (i == stray_at)
				send_sym(WS_X, pick_sym(base, narrow), 1'b0, 1'b0, NO_RES);
			send_sym(WS_Y, pick_sym(base, narrow), i == ny - 1, 1'b0, NO_RES);
		end
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		pair_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_lengths.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual lcs=%0d x=%0d y=%0d err=%0d",
					$time, res_ch.lcs_length, res_ch.x_length, res_ch.y_length, res_ch.error);
				fails++;
			end else begin
				want = pending_lengths.pop_front();
				check_field("lcs_length", int'(want.lcs), int'(res_ch.lcs_length));
				check_field("x_length", int'(want.xl), int'(res_ch.x_length));
				check_field("y_length", int'(want.yl), int'(res_ch.y_length));
				check_field("error", int'(want.err), int'(res_ch.error));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_lengths.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : result_sink
		int gap;
		bit held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && results_seen >= 10) begin
				// long hold: let the output fill and back up into the input
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 10);
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int r, k, start;
		fails = 0;
		results_seen = 0;
		items_sent = 0;
		drops = 0;
		cycles = 0;
		calm = 1'b0;
		clear_pair();
		arst_n <= 1'b0;
		sym_ch.valid <= 1'b0;
		sym_ch.which_string <= WS_X;
		sym_ch.symbol <= '0;
		sym_ch.last <= 1'b0;

		dir_rows = '{
			// empty x
			'{WS_Y, 8'h00, 1'b1, 7'd1, 1'b1, '{7'd0, 7'd0, 7'd1, 1'b0}},
			// last on an x request is ignored
			'{WS_X, 8'h55, 1'b1, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'h55, 1'b1, 7'd1, 1'b1, '{7'd1, 7'd1, 7'd1, 1'b0}},
			// x after y is dropped
			'{WS_X, 8'hA0, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'hA0, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_X, 8'h01, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'h01, 1'b1, 7'd1, 1'b1, '{7'd1, 7'd1, 7'd2, 1'b1}},
			// x overflow
			'{WS_X, 8'hFF, 1'b0, 7'd65, 1'b0, NO_RES},
			'{WS_Y, 8'hFF, 1'b1, 7'd1, 1'b1, '{7'd1, 7'd64, 7'd1, 1'b1}},
			// full length match, then y overflow on the last request
			'{WS_X, 8'h00, 1'b0, 7'd64, 1'b0, NO_RES},
			'{WS_Y, 8'h00, 1'b0, 7'd64, 1'b0, NO_RES},
			'{WS_Y, 8'h00, 1'b1, 7'd1, 1'b1, '{7'd64, 7'd64, 7'd64, 1'b1}},
			'{WS_X, 8'hAA, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_X, 8'h0F, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_X, 8'hF0, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_X, 8'hAA, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'hF0, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'hAA, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'h0F, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'hAA, 1'b1, 7'd1, 1'b0, NO_RES},
			'{WS_X, 8'h80, 1'b0, 7'd1, 1'b0, NO_RES},
			'{WS_Y, 8'h7F, 1'b1, 7'd1, 1'b0, NO_RES}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_ROWS; r++)
			for (k = 0; k < dir_rows[r].reps; k++)
				send_sym(dir_rows[r].ws, dir_rows[r].sym, dir_rows[r].lst,
					dir_rows[r].typed, dir_rows[r].want);

		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start >= CALM_AFTER)
				calm = 1'b1;
			random_pair();
		end
		sym_ch.valid <= 1'b0;

		while (pending_lengths.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d string pairs from %0d symbol requests, %0d of them dropped",
			results_seen, items_sent, drops);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
